@@ rtl/core/sfc_pkg.sv @@
// Shared types and constants for the scope frame CRC-16 appender.
// No dependencies; compiled first.
package sfc_pkg;

    typedef logic [15:0] t_crc;
    typedef logic [7:0]  t_byte;

    localparam t_crc CRC_INIT = 16'hFFFF;
    localparam t_crc CRC_POLY = 16'hA001;

    // Output sequencing codes for one frame-completing byte
    localparam logic [1:0] PH_DATA = 2'd0;
    localparam logic [1:0] PH_LOW  = 2'd1;
    localparam logic [1:0] PH_HIGH = 2'd2;

endpackage

@@ rtl/core/sfc_in_if.sv @@
// Input byte channel: valid/ready handshake with one payload byte.
// Depends on sfc_pkg.
interface sfc_in_if;
    import sfc_pkg::*;

    logic  valid;
    logic  ready;
    t_byte data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

@@ rtl/core/sfc_out_if.sv @@
// Output byte channel: valid/ready handshake with byte and frame flags.
// Depends on sfc_pkg.
interface sfc_out_if;
    import sfc_pkg::*;

    logic  valid;
    logic  ready;
    t_byte out_byte;
    logic  is_check_byte;
    logic  frame_end;
    logic  run_last;

    modport source (output valid, output out_byte, output is_check_byte,
                    output frame_end, output run_last, input ready);
    modport sink   (input valid, input out_byte, input is_check_byte,
                    input frame_end, input run_last, output ready);
endinterface

@@ rtl/core/sfc_crc_byte.sv @@
// Folds one byte into a reflected CRC-16 (poly 0xA001), eight bit steps unrolled.
// Depends on sfc_pkg.
module sfc_crc_byte (
    input  sfc_pkg::t_crc  i_crc,
    input  sfc_pkg::t_byte i_byte,
    output sfc_pkg::t_crc  o_crc
);
    import sfc_pkg::*;

    always_comb begin
        t_crc c;
        c = i_crc ^ {8'h00, i_byte};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        o_crc = c;
    end

endmodule

@@ rtl/core/scope_frame_crc16_appender.sv @@
// Scope frame builder: passes payload bytes through, appends CRC-16/MODBUS trailer.
// Depends on sfc_pkg, sfc_in_if, sfc_out_if, sfc_crc_byte.
//
//  channel | dir | payload                                         | handshake
//  i_in    | in  | data_byte[7:0]                                  | valid/ready
//  o_out   | out | out_byte[7:0], is_check_byte, frame_end, run_last | valid/ready
//
// One payload byte per cycle while o_out is ready; the byte that completes a frame holds the output
// register through payload, CRC low and CRC high before the next byte is taken.
// The CRC fold is one combinational step between the input and the output register.
// A new byte is accepted in the cycle the last result of the previous one transfers.
// Synchronous active-low reset loads the CRC with 0xFFFF and clears the byte count.
module scope_frame_crc16_appender #(
    parameter int PAYLOAD_BYTES = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    sfc_in_if.sink           i_in,
    sfc_out_if.source        o_out
);
    import sfc_pkg::*;

    localparam int CntW = $clog2(PAYLOAD_BYTES + 1);

    logic [CntW-1:0] r_count;
    t_crc            r_crc;
    t_crc            r_hold;
    logic            r_valid;
    logic [1:0]      r_phase;
    t_byte           r_byte;
    logic            r_chk;
    logic            r_fend;
    logic            r_last;

    t_crc            n_crc;
    logic [CntW:0]   n_count;
    logic            w_complete;
    logic            w_accept;
    logic            w_out_xfer;

    sfc_crc_byte u_crc (
        .i_crc  (r_crc),
        .i_byte (i_in.data_byte),
        .o_crc  (n_crc)
    );

    assign n_count    = {1'b0, r_count} + (CntW + 1)'(1);
    assign w_complete = n_count >= (CntW + 1)'(PAYLOAD_BYTES);
    assign w_out_xfer = r_valid && o_out.ready;
    assign i_in.ready = !r_valid || (o_out.ready && r_last);
    assign w_accept   = i_in.valid && i_in.ready;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_crc   <= CRC_INIT;
            r_valid <= 1'b0;
            r_phase <= PH_DATA;
        end else begin
            if (w_accept) begin
                r_valid <= 1'b1;
                r_phase <= PH_DATA;
                if (w_complete) begin
                    r_count <= '0;
                    r_crc   <= CRC_INIT;
                end else begin
                    r_count <= n_count[CntW-1:0];
                    r_crc   <= n_crc;
                end
            end else if (w_out_xfer) begin
                if (r_last) begin
                    r_valid <= 1'b0;
                end else begin
                    // advance through the trailer
                    case (r_phase)
                        PH_DATA: r_phase <= PH_LOW;
                        PH_LOW:  r_phase <= PH_HIGH;
                        default: r_phase <= PH_DATA;
                    endcase
                end
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte <= i_in.data_byte;
            r_chk  <= 1'b0;
            r_fend <= 1'b0;
            r_last <= !w_complete;
            r_hold <= n_crc;
        end else if (w_out_xfer && !r_last) begin
            case (r_phase)
                PH_DATA: begin
                    r_byte <= r_hold[7:0];
                    r_chk  <= 1'b1;
                    r_fend <= 1'b0;
                    r_last <= 1'b0;
                end
                default: begin
                    r_byte <= r_hold[15:8];
                    r_chk  <= 1'b1;
                    r_fend <= 1'b1;
                    r_last <= 1'b1;
                end
            endcase
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.out_byte      = r_byte;
    assign o_out.is_check_byte = r_chk;
    assign o_out.frame_end     = r_fend;
    assign o_out.run_last      = r_last;

    a_fend_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.frame_end |-> o_out.is_check_byte && o_out.run_last)
        else $error("frame end not on last check byte");

    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.run_last |-> !i_in.ready)
        else $error("input taken while trailer pending");

    a_trailer_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready && !o_out.run_last |=> o_out.valid && o_out.is_check_byte)
        else $error("trailer byte missing after transfer");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_count} < (CntW + 1)'(PAYLOAD_BYTES))
        else $error("payload count past frame length");

endmodule

@@ dv/scope_frame_crc16_appender_tb.sv @@
// Testbench for scope_frame_crc16_appender: random byte streams with random stalls on both sides,
// checked against a CRC-16/MODBUS frame tracker kept in the testbench.
// Depends on sfc_pkg, sfc_in_if, sfc_out_if and the RTL top level.
module scope_frame_crc16_appender_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sfc_pkg::*;

    localparam int FRAME_LEN     = 8;
    localparam int STALL_LIMIT   = 1000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_ITEMS  = 300;
    localparam int BLOCK_ITEMS   = 40;

    typedef struct packed {
        t_byte data;
        logic  check;
        logic  frame_done;
        logic  input_done;
    } frame_out_t;

    // Tracks the running frame CRC and queues the bytes the block must send.
    class frame_crc_tracker;
        t_crc       crc;
        logic [3:0] count;
        int         frame_len;
        int         mismatch_count;
        frame_out_t pending_bytes[$];

        function new(int len);
            frame_len      = len;
            crc            = CRC_INIT;
            count          = '0;
            mismatch_count = 0;
        endfunction

        function t_crc fold(t_crc c_in, t_byte b);
            t_crc c;
            c = c_in ^ {8'h00, b};
            for (int i = 0; i < 8; i++) begin
                if (c[0]) begin
                    c = (c >> 1) ^ CRC_POLY;
                end else begin
                    c = c >> 1;
                end
            end
            return c;
        endfunction

        function int outstanding();
            return pending_bytes.size();
        endfunction

        function void take_payload(t_byte b);
            logic [3:0] nxt;
            nxt = count + 4'd1;
            crc = fold(crc, b);
            if (nxt >= frame_len || nxt == 4'd0) begin
                pending_bytes.push_back('{b, 1'b0, 1'b0, 1'b0});
                pending_bytes.push_back('{crc[7:0], 1'b1, 1'b0, 1'b0});
                pending_bytes.push_back('{crc[15:8], 1'b1, 1'b1, 1'b1});
                crc   = CRC_INIT;
                count = '0;
            end else begin
                pending_bytes.push_back('{b, 1'b0, 1'b0, 1'b1});
                count = nxt;
            end
        endfunction

        task flag_mismatch(string what);
            mismatch_count++;
            $display("%t MISMATCH: %s", $realtime, what);
        endtask

        task match_output(frame_out_t got);
            frame_out_t want;
            if (pending_bytes.size() == 0) begin
                flag_mismatch($sformatf("unexpected transfer byte=%02h chk=%0b end=%0b last=%0b",
                                        got.data, got.check, got.frame_done, got.input_done));
                return;
            end
            want = pending_bytes.pop_front();
            if (got.data != want.data)
                flag_mismatch($sformatf("out_byte %02h, want %02h", got.data, want.data));
            if (got.check != want.check)
                flag_mismatch($sformatf("is_check_byte %0b, want %0b", got.check, want.check));
            if (got.frame_done != want.frame_done)
                flag_mismatch($sformatf("frame_end %0b, want %0b",
                                        got.frame_done, want.frame_done));
            if (got.input_done != want.input_done)
                flag_mismatch($sformatf("run_last %0b, want %0b",
                                        got.input_done, want.input_done));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    sfc_in_if  in_if();
    sfc_out_if out_if();

    frame_crc_tracker tracker = new(FRAME_LEN);

    bit in_idle;
    bit out_idle;
    int quiet_cycles;

    scope_frame_crc16_appender #(
        .PAYLOAD_BYTES(FRAME_LEN)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Abort when neither side moves a transfer for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task send_payload(t_byte b);
        int gap;
        gap = in_idle ? $urandom_range(0, 6) : 0;
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.data_byte <= b;
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
        tracker.take_payload(b);
    endtask

    task wait_drained();
        while (tracker.outstanding() != 0) @(posedge i_clk);
    endtask

    // Output side: random stall before each transfer, then check it.
    initial begin
        int stall;
        out_if.ready <= 1'b0;
        // hold until reset has been released
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = out_idle ? $urandom_range(0, 6) : 0;
            if (stall != 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_if.valid && out_if.ready));
            tracker.match_output('{out_if.out_byte, out_if.is_check_byte,
                                   out_if.frame_end, out_if.run_last});
        end
    end

    initial begin
        t_byte directed_bytes[$];
        t_byte b;
        int    pick;

        quiet_cycles    = 0;
        in_idle         = 1'b1;
        out_idle        = 1'b1;
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.data_byte <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Three whole frames: all zeros, all ones, then walking and mixed patterns.
        for (int i = 0; i < FRAME_LEN; i++) directed_bytes.push_back(8'h00);
        for (int i = 0; i < FRAME_LEN; i++) directed_bytes.push_back(8'hFF);
        directed_bytes = {directed_bytes, 8'h01, 8'h02, 8'h80, 8'h7F,
                          8'hAA, 8'h55, 8'h0F, 8'hF0};
        foreach (directed_bytes[i]) send_payload(directed_bytes[i]);

        // Hold off the sender until every trailer byte has arrived.
        in_if.valid <= 1'b0;
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % BLOCK_ITEMS == 0) begin
                // Cycle through idle on/off combinations, starting with no idling at all.
                in_idle  = ((n / BLOCK_ITEMS) % 4) >= 2;
                out_idle = ((n / BLOCK_ITEMS) % 2) == 1;
            end
            pick = $urandom_range(0, 15);
            if (pick == 0) begin
                b = 8'h00;
            end else if (pick == 1) begin
                b = 8'hFF;
            end else begin
                b = t_byte'($urandom);
            end
            send_payload(b);
        end

        in_if.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (tracker.mismatch_count == 0 && tracker.outstanding() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
